@@ rtl/ecs_pkg.sv @@
package ecs_pkg;

	// Checksum variant codes held in the mode register
	localparam logic [1:0] MODE_BOOT  = 2'd0;  // boot region, 32-bit
	localparam logic [1:0] MODE_ENTRY = 2'd1;  // entry set, 16-bit
	localparam logic [1:0] MODE_NAME  = 2'd2;  // name hash, 16-bit

	localparam int unsigned DATA_W = 16;
	localparam int unsigned SUM_W  = 32;
	localparam int unsigned POS_W  = 7;

	// Stream positions and limits
	localparam logic [POS_W-1:0] POS_MAX       = 7'd127;
	localparam logic [POS_W-1:0] POS_VBR_FLAGS = 7'd106;
	localparam logic [POS_W-1:0] POS_VBR_DRIVE = 7'd107;
	localparam logic [POS_W-1:0] POS_VBR_USE   = 7'd112;
	localparam logic [POS_W-1:0] POS_ES_CSUM_L = 7'd2;
	localparam logic [POS_W-1:0] POS_ES_CSUM_H = 7'd3;

	// ASCII lower-case range and the upper-case offset
	localparam logic [DATA_W-1:0] CHAR_LOWER_A = 16'h0061;
	localparam logic [DATA_W-1:0] CHAR_LOWER_Z = 16'h007A;
	localparam logic [DATA_W-1:0] CASE_OFFSET  = 16'd32;

	// One input item as held in the input stage
	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              first;
		logic              last;
		logic              vbr;
	} item_t;

endpackage

@@ rtl/ecs_step.sv @@
module ecs_step
	import ecs_pkg::*;
(
	input  logic [1:0]       mode,
	input  item_t            item,
	input  logic [SUM_W-1:0] sum,
	input  logic [POS_W-1:0] pos,
	output logic [SUM_W-1:0] next_sum,
	output logic [POS_W-1:0] next_pos
);

	// Rotate right by one, then add a byte
	function automatic logic [15:0] step16(input logic [15:0] s, input logic [7:0] b);
		step16 = {s[0], s[15:1]} + {8'd0, b};
	endfunction

	function automatic logic [31:0] step32(input logic [31:0] s, input logic [7:0] b);
		step32 = {s[0], s[31:1]} + {24'd0, b};
	endfunction

	logic [SUM_W-1:0]  base_sum;
	logic [POS_W-1:0]  base_pos;
	logic              skip_boot;
	logic              skip_entry;
	logic [DATA_W-1:0] ch;
	logic [15:0]       hash_lo;
	logic [15:0]       hash_hi;

	// Start of a region clears sum and position
	assign base_sum = item.first ? '0 : sum;
	assign base_pos = item.first ? '0 : pos;

	assign skip_boot = item.vbr && (base_pos == POS_VBR_FLAGS || base_pos == POS_VBR_DRIVE ||
		base_pos == POS_VBR_USE);
	assign skip_entry = (base_pos == POS_ES_CSUM_L) || (base_pos == POS_ES_CSUM_H);

	// Name hash: upper-case ASCII, then low byte and high byte
	assign ch = (item.data >= CHAR_LOWER_A && item.data <= CHAR_LOWER_Z) ?
		item.data - CASE_OFFSET : item.data;
	assign hash_lo = step16(base_sum[15:0], ch[7:0]);
	assign hash_hi = step16(hash_lo, ch[15:8]);

	// Sum update per variant
	always_comb begin
		case (mode)
			MODE_BOOT: begin
				next_sum = skip_boot ? base_sum : step32(base_sum, item.data[7:0]);
			end
			MODE_ENTRY: begin
				next_sum = skip_entry ? {16'd0, base_sum[15:0]} :
					{16'd0, step16(base_sum[15:0], item.data[7:0])};
			end
			MODE_NAME: begin
				next_sum = {16'd0, hash_hi};
			end
			default: begin
				next_sum = base_sum;
			end
		endcase
	end

	// Position saturates
	assign next_pos = (base_pos == POS_MAX) ? POS_MAX : base_pos + 7'd1;

endmodule

@@ rtl/exfat_checksum_engine.sv @@
// Channel   Dir  Bits  Contents
// s_axis    in   16    tdata: data_value; tuser: first_item, vbr_skip; tlast: last_item
// m_axis    out  32    tdata: checksum_value; tlast: is_final
// cfg       in   2     checksum_mode write, always ready
//
// One item per cycle while the output is not stalled. An input item passes through
// the input stage, then the sum/result register; the sum is fed back from its register.
// arst_n clears the sum, the position, the mode and both valid flags.
// A stalled output holds its result; the input stage keeps taking items until it
// is full behind a stalled output.
module exfat_checksum_engine
	import ecs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] data_value
	input  logic [1:0]  s_axis_tuser,   // [0] first_item, [1] vbr_skip
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] checksum_value
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data
);

	item_t            item_s1;
	logic             valid_s1;
	logic [SUM_W-1:0] sum_q;
	logic [POS_W-1:0] pos_q;
	logic [1:0]       mode_q;
	logic [SUM_W-1:0] out_data_q;
	logic             out_last_q;
	logic             out_valid_q;
	logic [SUM_W-1:0] next_sum;
	logic [POS_W-1:0] next_pos;
	logic             adv;
	logic             in_xfer;

	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BOOT;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.data  <= s_axis_tdata;
			item_s1.first <= s_axis_tuser[0];
			item_s1.vbr   <= s_axis_tuser[1];
			item_s1.last  <= s_axis_tlast;
		end
	end

	ecs_step u_step (
		.mode     (mode_q),
		.item     (item_s1),
		.sum      (sum_q),
		.pos      (pos_q),
		.next_sum (next_sum),
		.next_pos (next_pos)
	);

	// Running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			pos_q <= '0;
		end else if (adv) begin
			sum_q <= next_sum;
			pos_q <= next_pos;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= next_sum;
			out_last_q <= item_s1.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	// 16-bit variants keep the upper half clear
	a_upper_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (mode_q == MODE_ENTRY || mode_q == MODE_NAME) |=> sum_q[31:16] == 16'd0)
		else $error("upper sum bits set in a 16-bit mode");

	// A region start leaves the position at one
	a_first_pos: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.first |=> pos_q == 7'd1)
		else $error("position not restarted on first item");

	// Result register mirrors the stored sum after an update
	a_out_sum: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_axis_tvalid && m_axis_tdata == sum_q)
		else $error("result does not match running sum");

endmodule
